[sv/assert_macros.svh]
// Assertion helpers for the block tracker. Bodies expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define NBT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nack_block_tracker: assertion failed");

`define NBT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nack_block_tracker: assertion failed");

`else

`define NBT_ASSERT_IMP(label, ante, cons)
`define NBT_ASSERT_NXT(label, ante, cons)

`endif

`endif

[sv/nbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nbt_pkg;

  localparam int MAX_BLOCKS  = 4096;
  localparam int BLOCK_BYTES = 1024;
  localparam int NACK_WINDOW = 16;

  // bitmap storage: one bit per block, packed into words
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  // field widths
  localparam int SIZE_W  = 23;
  localparam int BLK_W   = 13;
  localparam int OFF_W   = 22;
  localparam int LEN_W   = 11;
  localparam int MARK_W  = 16;
  localparam int BB_SHIFT = $clog2(BLOCK_BYTES);
  localparam int FOUND_W  = $clog2(NACK_WINDOW + 1);

  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(MAX_BLOCKS * BLOCK_BYTES);

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_MISSING = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_RANGE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [WIDX_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } ram_req_t;

endpackage

`default_nettype wire

[sv/nbt_map_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module nbt_map_ram (
  input  wire logic                          clk,
  input  wire nbt_pkg::ram_req_t             req,
  output logic [nbt_pkg::WORD_BITS-1:0]      rdata
);

  logic [nbt_pkg::WORD_BITS-1:0] mem [nbt_pkg::MAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    // read data holds until the next read
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

[sv/nbt_zero_find.sv]
`timescale 1ns / 1ps
`default_nettype none

// Lowest set bit of a bitmap word.
module nbt_zero_find (
  input  wire logic [nbt_pkg::WORD_BITS-1:0] mask,
  output logic                               found,
  output logic [nbt_pkg::BIT_W-1:0]          pos
);

  always_comb begin
    pos = '0;
    // scan downward so the lowest set bit wins
    for (int b = nbt_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (mask[b]) begin
        pos = nbt_pkg::BIT_W'(b);
      end
    end
    found = |mask;
  end

endmodule

`default_nettype wire

[sv/nack_block_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Receive-side tracker for a block transfer with negative acknowledgements. The
// received bitmap lives in a 128 x 32 single-port RAM; after reset a clearing pass
// zeroes it one word per cycle, and in_ready stays low until that pass ends.
// A data block is accepted, its bitmap word is read, then checked and written
// back, and it yields at most one word; an out-of-range block is accepted and
// then reported. A flush walks the bitmap one RAM word at a time through one
// find-first unit: each word is read, loaded and scanned, and each missing entry
// found is reported in turn. Results leave through a one-word output register,
// so the tracker moves on while the last word waits for out_ready.
module nack_block_tracker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [nbt_pkg::SIZE_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [nbt_pkg::BLK_W-1:0]     in_block_number,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_kind,
  output logic [nbt_pkg::OFF_W-1:0]          out_write_offset,
  output logic [nbt_pkg::LEN_W-1:0]          out_write_length,
  output logic [nbt_pkg::BLK_W-1:0]          out_missing_block,
  output logic [nbt_pkg::MARK_W-1:0]         out_batch_mark,
  output logic                               out_last
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BLK_RD,
    S_BLK_CHK,
    S_RANGE,
    S_FL_RD,
    S_FL_LOAD,
    S_FL_SCAN,
    S_FL_END
  } state_t;

  state_t                              state_r;
  logic [nbt_pkg::WIDX_W-1:0]          clr_idx_r;
  logic [nbt_pkg::SIZE_W-1:0]          file_size_r;
  logic [nbt_pkg::MARK_W-1:0]          flush_count_r;
  logic [nbt_pkg::BLK_W-1:0]           blk_r;
  logic [nbt_pkg::WIDX_W-1:0]          word_idx_r;
  logic [nbt_pkg::WORD_BITS-1:0]       zmask_r;
  logic [nbt_pkg::FOUND_W-1:0]         found_r;
  logic                                have_pend_r;
  logic [nbt_pkg::BLK_W-1:0]           pend_r;

  logic                                out_valid_r;
  nbt_pkg::kind_t                      out_kind_r;
  logic [nbt_pkg::OFF_W-1:0]           out_offset_r;
  logic [nbt_pkg::LEN_W-1:0]           out_length_r;
  logic [nbt_pkg::BLK_W-1:0]           out_missing_r;
  logic [nbt_pkg::MARK_W-1:0]          out_mark_r;
  logic                                out_last_r;

  logic [nbt_pkg::SIZE_W-1:0]          eff_size;
  logic [nbt_pkg::SIZE_W-1:0]          size_m1;
  logic [nbt_pkg::BLK_W-1:0]           block_count;
  logic [nbt_pkg::BLK_W-1:0]           bc_m1;
  logic [nbt_pkg::LEN_W-1:0]           last_len;
  logic [nbt_pkg::WIDX_W-1:0]          last_word;
  logic [nbt_pkg::BIT_W:0]             last_rem;

  logic [nbt_pkg::BLK_W-1:0]           blk_m1;
  logic [nbt_pkg::WIDX_W-1:0]          blk_word;
  logic [nbt_pkg::BIT_W-1:0]           blk_bit;
  logic                                blk_seen;

  logic [nbt_pkg::WORD_BITS-1:0]       valid_mask;
  logic [nbt_pkg::WORD_BITS-1:0]       rd_data;
  logic                                zf_found;
  logic [nbt_pkg::BIT_W-1:0]           zf_pos;
  logic [nbt_pkg::BLK_W-1:0]           miss_num;
  logic [nbt_pkg::FOUND_W-1:0]         found_nxt;
  logic                                out_free;
  logic                                out_load;
  nbt_pkg::ram_req_t                   ram_req;

  // block count and last block length from the file size
  always_comb begin
    if (file_size_r == '0) begin
      eff_size = nbt_pkg::SIZE_W'(1);
    end else if (file_size_r > nbt_pkg::SIZE_CAP) begin
      eff_size = nbt_pkg::SIZE_CAP;
    end else begin
      eff_size = file_size_r;
    end
    size_m1     = eff_size - nbt_pkg::SIZE_W'(1);
    block_count = nbt_pkg::BLK_W'(size_m1 >> nbt_pkg::BB_SHIFT) + nbt_pkg::BLK_W'(1);
    bc_m1       = block_count - nbt_pkg::BLK_W'(1);
    last_len    = nbt_pkg::LEN_W'(size_m1 & nbt_pkg::SIZE_W'(nbt_pkg::BLOCK_BYTES - 1))
                  + nbt_pkg::LEN_W'(1);
    last_word   = nbt_pkg::WIDX_W'(bc_m1 >> nbt_pkg::BIT_W);
    last_rem    = (nbt_pkg::BIT_W + 1)'(bc_m1[nbt_pkg::BIT_W-1:0])
                  + (nbt_pkg::BIT_W + 1)'(1);
  end

  assign blk_m1   = blk_r - nbt_pkg::BLK_W'(1);
  assign blk_word = nbt_pkg::WIDX_W'(blk_m1 >> nbt_pkg::BIT_W);
  assign blk_bit  = blk_m1[nbt_pkg::BIT_W-1:0];
  assign blk_seen = rd_data[blk_bit];

  // only blocks up to the block count count as missing
  always_comb begin
    for (int b = 0; b < nbt_pkg::WORD_BITS; b++) begin
      valid_mask[b] = (word_idx_r != last_word) ||
                      ((nbt_pkg::BIT_W + 1)'(b) < last_rem);
    end
  end

  assign miss_num  = nbt_pkg::BLK_W'({word_idx_r, zf_pos}) + nbt_pkg::BLK_W'(1);
  assign found_nxt = found_r + nbt_pkg::FOUND_W'(1);
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  // a new word enters the output register this cycle
  assign out_load = ((state_r == S_BLK_CHK) && !blk_seen && out_free) ||
                    ((state_r == S_RANGE) && out_free) ||
                    ((state_r == S_FL_SCAN) && zf_found && have_pend_r && out_free) ||
                    ((state_r == S_FL_END) && out_free);

  always_comb begin
    ram_req       = '0;
    ram_req.addr  = word_idx_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_req.we   = 1'b1;
        ram_req.addr = clr_idx_r;
      end
      S_BLK_RD: begin
        ram_req.re   = 1'b1;
        ram_req.addr = blk_word;
      end
      S_BLK_CHK: begin
        ram_req.we    = !blk_seen && out_free;
        ram_req.addr  = blk_word;
        ram_req.wdata = rd_data | (nbt_pkg::WORD_BITS'(1) << blk_bit);
      end
      S_FL_RD: begin
        ram_req.re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  nbt_map_ram u_map (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rd_data)
  );

  nbt_zero_find u_find (
    .mask  (zmask_r),
    .found (zf_found),
    .pos   (zf_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_idx_r     <= '0;
      file_size_r   <= nbt_pkg::SIZE_W'(1);
      flush_count_r <= '0;
      found_r       <= '0;
      have_pend_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        file_size_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + nbt_pkg::WIDX_W'(1);
          if (clr_idx_r == nbt_pkg::WIDX_W'(nbt_pkg::MAP_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            blk_r <= in_block_number;
            if (in_block_number == '0) begin
              flush_count_r <= flush_count_r + nbt_pkg::MARK_W'(1);
              word_idx_r    <= '0;
              found_r       <= '0;
              have_pend_r   <= 1'b0;
              state_r       <= S_FL_RD;
            end else if (in_block_number > block_count) begin
              state_r <= S_RANGE;
            end else begin
              state_r <= S_BLK_RD;
            end
          end
        end
        S_BLK_RD: begin
          state_r <= S_BLK_CHK;
        end
        S_BLK_CHK: begin
          if (blk_seen) begin
            // duplicate: drop silently
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_kind_r    <= nbt_pkg::KIND_WRITE;
            out_offset_r  <= nbt_pkg::OFF_W'(blk_m1) << nbt_pkg::BB_SHIFT;
            out_length_r  <= (blk_r == block_count) ? last_len
                                                    : nbt_pkg::LEN_W'(nbt_pkg::BLOCK_BYTES);
            out_missing_r <= '0;
            out_mark_r    <= '0;
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        S_RANGE: begin
          if (out_free) begin
            out_kind_r    <= nbt_pkg::KIND_RANGE;
            out_offset_r  <= '0;
            out_length_r  <= '0;
            out_missing_r <= '0;
            out_mark_r    <= '0;
            out_last_r    <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        S_FL_RD: begin
          state_r <= S_FL_LOAD;
        end
        S_FL_LOAD: begin
          zmask_r <= ~rd_data & valid_mask;
          state_r <= S_FL_SCAN;
        end
        S_FL_SCAN: begin
          if (zf_found) begin
            // hold one entry back so the final one can carry last
            if (!have_pend_r || out_free) begin
              if (have_pend_r) begin
                out_kind_r    <= nbt_pkg::KIND_MISSING;
                out_offset_r  <= '0;
                out_length_r  <= '0;
                out_missing_r <= pend_r;
                out_mark_r    <= flush_count_r;
                out_last_r    <= 1'b0;
              end
              pend_r          <= miss_num;
              have_pend_r     <= 1'b1;
              found_r         <= found_nxt;
              zmask_r[zf_pos] <= 1'b0;
              if (found_nxt == nbt_pkg::FOUND_W'(nbt_pkg::NACK_WINDOW)) begin
                state_r <= S_FL_END;
              end
            end
          end else if (word_idx_r == last_word) begin
            state_r <= S_FL_END;
          end else begin
            word_idx_r <= word_idx_r + nbt_pkg::WIDX_W'(1);
            state_r    <= S_FL_RD;
          end
        end
        S_FL_END: begin
          if (out_free) begin
            out_offset_r <= '0;
            out_length_r <= '0;
            out_last_r   <= 1'b1;
            if (have_pend_r) begin
              out_kind_r    <= nbt_pkg::KIND_MISSING;
              out_missing_r <= pend_r;
              out_mark_r    <= flush_count_r;
            end else begin
              out_kind_r    <= nbt_pkg::KIND_DONE;
              out_missing_r <= '0;
              out_mark_r    <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_write_offset  = out_offset_r;
  assign out_write_length  = out_length_r;
  assign out_missing_block = out_missing_r;
  assign out_batch_mark    = out_mark_r;
  assign out_last          = out_last_r;

  `NBT_ASSERT_IMP(a_ram_excl, ram_req.we, !ram_req.re)
  `NBT_ASSERT_IMP(a_found_cap, state_r != S_CLEAR, found_r <= nbt_pkg::FOUND_W'(nbt_pkg::NACK_WINDOW))
  `NBT_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid_r && !in_ready)
  `NBT_ASSERT_NXT(a_pend_emit, state_r == S_FL_SCAN && have_pend_r && zf_found && out_free, out_valid_r && out_kind_r == nbt_pkg::KIND_MISSING && !out_last_r)
  `NBT_ASSERT_IMP(a_word_bound, state_r == S_FL_RD || state_r == S_FL_LOAD || state_r == S_FL_SCAN, word_idx_r <= last_word)

endmodule

`default_nettype wire
